// ===== rtl/utar_pkg.sv =====
// Package for the unsigned-to-ASCII radix unit: payload types, job type, codes and constants.
package utar_pkg;

    localparam int VALUE_W         = 64;
    localparam int BCD_DIGITS      = 20;
    localparam int MAX_DIGITS      = 22;
    localparam int DIGIT_IDX_W     = $clog2(MAX_DIGITS);
    localparam int DABBLE_STEPS    = VALUE_W;
    localparam int STEP_CNT_W      = $clog2(DABBLE_STEPS);
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [1:0] FUNC_DEC    = 2'd0;
    localparam logic [1:0] FUNC_HEX_LO = 2'd1;
    localparam logic [1:0] FUNC_HEX_UP = 2'd2;
    localparam logic [1:0] FUNC_OCT    = 2'd3;

    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_UPPER_A = 7'h41;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         func;
    } in_t;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       last;
    } out_t;

    typedef logic [MAX_DIGITS-1:0][3:0] digits_t;

    typedef struct packed {
        digits_t                digits;
        logic [DIGIT_IDX_W-1:0] top_idx;
        logic                   upper;
    } job_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CONV,
        FS_DONE
    } front_state_t;

endpackage

// ===== rtl/utar_front.sv =====
// Front end: accepts a value, converts it to radix digits and finds the leading digit.
module utar_front
    import utar_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic job_valid,
    input  logic job_ready,
    output job_t job_data
);

    localparam int SR_W = BCD_DIGITS * 4 + VALUE_W;

    front_state_t state_reg, state_next;
    logic [SR_W-1:0]       sr_reg;
    logic [SR_W-1:0]       sr_step;
    logic [STEP_CNT_W-1:0] cnt_reg;
    digits_t               digits_reg;
    digits_t               load_digits;
    logic                  upper_reg;
    logic                  accept;

    function automatic logic [SR_W-1:0] dabble(input logic [SR_W-1:0] x);
        logic [SR_W-1:0] y;
        logic [3:0]      d;
        y = x;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            d = y[VALUE_W + 4*i +: 4];
            if (d >= 4'd5) begin
                d = d + 4'd3;
            end
            y[VALUE_W + 4*i +: 4] = d;
        end
        return {y[SR_W-2:0], 1'b0};
    endfunction

    function automatic logic [DIGIT_IDX_W-1:0] lead_idx(input digits_t d);
        logic [DIGIT_IDX_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (d[i] != 4'd0) begin
                n = DIGIT_IDX_W'(i);
            end
        end
        return n;
    endfunction

    assign sr_step = dabble(sr_reg);

    always_comb begin
        logic [3*MAX_DIGITS-1:0] oct_pad;
        oct_pad     = {{(3*MAX_DIGITS-VALUE_W){1'b0}}, s_payload.value};
        load_digits = '0;
        if (s_payload.func == FUNC_OCT) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                load_digits[i] = {1'b0, oct_pad[3*i +: 3]};
            end
        end else begin
            load_digits = digits_t'(s_payload.value);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE: begin
                if (s_valid) begin
                    state_next = (s_payload.func == FUNC_DEC) ? FS_CONV : FS_DONE;
                end
            end
            FS_CONV: begin
                if (cnt_reg == STEP_CNT_W'(DABBLE_STEPS - 1)) begin
                    state_next = FS_DONE;
                end
            end
            FS_DONE: begin
                if (job_ready) begin
                    state_next = FS_IDLE;
                end
            end
            default: state_next = FS_IDLE;
        endcase
    end

    always_comb begin
        s_ready           = (state_reg == FS_IDLE);
        job_valid         = (state_reg == FS_DONE);
        job_data.digits   = digits_reg;
        job_data.top_idx  = lead_idx(digits_reg);
        job_data.upper    = upper_reg;
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sr_reg     <= {{(BCD_DIGITS*4){1'b0}}, s_payload.value};
            cnt_reg    <= '0;
            digits_reg <= load_digits;
            upper_reg  <= (s_payload.func == FUNC_HEX_UP);
        end else if (state_reg == FS_CONV) begin
            sr_reg  <= sr_step;
            cnt_reg <= cnt_reg + STEP_CNT_W'(1);
            if (cnt_reg == STEP_CNT_W'(DABBLE_STEPS - 1)) begin
                digits_reg <= digits_t'(sr_step[SR_W-1:VALUE_W]);
            end
        end
    end

endmodule

// ===== rtl/utar_queue.sv =====
// Small job queue between the conversion front end and the character back end.
module utar_queue
    import utar_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/utar_back.sv =====
// Back end: walks a job's digits from the leading one down, one ASCII character per cycle unless stalled.
module utar_back
    import utar_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic job_valid,
    output logic job_ready,
    input  job_t job_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    logic                   busy_reg;
    job_t                   job_reg;
    logic [DIGIT_IDX_W-1:0] idx_reg;
    logic                   m_valid_reg;
    out_t                   out_reg;
    logic                   emit;

    function automatic logic [6:0] to_char(input logic [3:0] d, input logic upper);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = ASCII_ZERO + 7'(d);
        end else begin
            c = (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + 7'(d - 4'd10);
        end
        return c;
    endfunction

    assign job_ready = !busy_reg;
    assign emit      = busy_reg && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (job_valid && !busy_reg) begin
                busy_reg <= 1'b1;
            end else if (emit && (idx_reg == '0)) begin
                busy_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_valid && !busy_reg) begin
            job_reg <= job_data;
            idx_reg <= job_data.top_idx;
        end else if (emit) begin
            out_reg.digit_char <= to_char(job_reg.digits[idx_reg], job_reg.upper);
            out_reg.last       <= (idx_reg == '0);
            if (idx_reg != '0) begin
                idx_reg <= idx_reg - DIGIT_IDX_W'(1);
            end
        end
    end

endmodule

// ===== rtl/unsigned_to_ascii_radix_unit.sv =====
// Top level: converts a 64-bit unsigned value to ASCII digits in decimal, hex or octal.
// Decimal values pass through the 64-step shift-and-add-3 loop in the front end; hex and octal
// skip it. The front end holds one number at a time and takes no new one until its job is
// handed on; the back end emits one character per cycle while a number is in progress and
// the output is not stalled.
// Reset: aresetn, synchronous, active low, clears all control state; no clearing pass.
module unsigned_to_ascii_radix_unit
    import utar_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    logic fq_valid, fq_ready;
    job_t fq_data;
    logic qb_valid, qb_ready;
    job_t qb_data;

    utar_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job_data  (fq_data)
    );

    utar_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    utar_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job_data  (qb_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ===== rtl/utar_checker.sv =====
// Port-level checker for the radix unit, bound to the top level.
module utar_checker
    import utar_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input in_t  s_payload,
    input logic m_valid,
    input logic m_ready,
    input out_t m_payload
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_payload))
        else $error("input transaction changed while waiting");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result transaction changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("front end took a second transaction while converting");

    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.digit_char >= 7'h30 && m_payload.digit_char <= 7'h39)
                 || (m_payload.digit_char >= 7'h61 && m_payload.digit_char <= 7'h66)
                 || (m_payload.digit_char >= 7'h41 && m_payload.digit_char <= 7'h46))
        else $error("character outside the digit set");

endmodule

bind unsigned_to_ascii_radix_unit utar_checker u_utar_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

// ===== bench/utar_char_checker.sv =====
// Checker for the radix unit: predicts the digit characters and last flags of each number and compares them.
module utar_char_checker
    import utar_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_payload,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_payload,
    output int   fail_count,
    output int   pending_chars
);
    timeunit 1ns;
    timeprecision 1ps;

    out_t expected_chars[$];

    function automatic logic [6:0] nibble_char(logic [3:0] d, logic upper);
        if (d < 4'd10) return ASCII_ZERO + 7'(d);
        return (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + 7'(d - 4'd10);
    endfunction

    // digits are gathered least significant first, then queued most significant first
    function automatic void push_radix_digits(in_t item);
        logic [63:0] v;
        logic [6:0]  rev [MAX_DIGITS];
        int          n;
        out_t        e;
        v = item.value;
        n = 0;
        do begin
            case (item.func)
                FUNC_HEX_LO: begin
                    rev[n] = nibble_char(v[3:0], 1'b0);
                    v = v >> 4;
                end
                FUNC_HEX_UP: begin
                    rev[n] = nibble_char(v[3:0], 1'b1);
                    v = v >> 4;
                end
                FUNC_OCT: begin
                    rev[n] = ASCII_ZERO + 7'(v[2:0]);
                    v = v >> 3;
                end
                default: begin
                    rev[n] = ASCII_ZERO + 7'(v % 64'd10);
                    v = v / 64'd10;
                end
            endcase
            n++;
        end while (v != 64'd0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            e.digit_char = rev[k];
            e.last       = (k == 0);
            expected_chars.push_back(e);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_chars.delete();
            fail_count = 0;
        end else begin
            if (s_valid && s_ready) push_radix_digits(s_payload);
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected transaction: digit_char %h last %b",
                           m_payload.digit_char, m_payload.last);
                    fail_count++;
                end else begin
                    if (m_payload.digit_char !== expected_chars[0].digit_char) begin
                        $error("digit_char: expected %h, got %h",
                               expected_chars[0].digit_char, m_payload.digit_char);
                        fail_count++;
                    end
                    if (m_payload.last !== expected_chars[0].last) begin
                        $error("last: expected %b, got %b",
                               expected_chars[0].last, m_payload.last);
                        fail_count++;
                    end
                    void'(expected_chars.pop_front());
                end
            end
        end
        pending_chars <= expected_chars.size();
    end

endmodule

// ===== bench/tb_unsigned_to_ascii_radix_unit.sv =====
// Testbench top for the radix unit: clock, reset, traffic on both channels and the verdict.
module tb_unsigned_to_ascii_radix_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import utar_pkg::*;

    typedef enum logic [1:0] {
        RX_RANDOM,
        RX_FREE,
        RX_HOLD
    } rx_mode_t;

    localparam int HOLD_CYCLES = 400;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    in_t      s_payload;
    logic     m_valid;
    logic     m_ready;
    out_t     m_payload;
    int       fail_count;
    int       pending_chars;
    rx_mode_t rx_mode;
    bit       tx_idle_en;

    unsigned_to_ascii_radix_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    utar_char_checker char_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_payload     (m_payload),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side: random stalls, a clean stretch, or one long hold-off
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_mode == RX_HOLD) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_mode = RX_RANDOM;
            end else if (rx_mode == RX_FREE) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 16);
            end
        end
    end

    task automatic send_number(logic [63:0] v, logic [1:0] f);
        in_t item;
        item.value = v;
        item.func  = f;
        if (tx_idle_en && $urandom_range(0, 99) < 16) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 16);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_chars != 0) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0: return v;
            1: return v >> $urandom_range(1, 63);
            2: return 64'($urandom_range(0, 1000));
            default: return ~(v >> $urandom_range(0, 8));
        endcase
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) send_number(rand_value(), 2'($urandom_range(0, 3)));
    endtask

    initial begin
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_payload  <= '0;
        rx_mode    = RX_RANDOM;
        tx_idle_en = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // zero and all ones in every format
        for (int f = 0; f < 4; f++) begin
            send_number(64'd0, 2'(f));
            send_number('1, 2'(f));
        end
        send_number(64'd9, FUNC_DEC);
        send_number(64'd10, FUNC_DEC);
        send_number(64'd10000000000000000000, FUNC_DEC);
        send_number(64'd9999999999999999999, FUNC_DEC);
        send_number(64'd15, FUNC_HEX_LO);
        send_number(64'd16, FUNC_HEX_UP);
        send_number(64'hfedcba9876543210, FUNC_HEX_LO);
        send_number(64'hfedcba9876543210, FUNC_HEX_UP);
        send_number(64'd7, FUNC_OCT);
        send_number(64'd8, FUNC_OCT);
        send_number(64'h8000000000000000, FUNC_OCT);
        send_number(64'haaaaaaaaaaaaaaaa, FUNC_DEC);
        send_number(64'h5555555555555555, FUNC_OCT);

        send_random(30);

        // long output stall while inputs keep coming
        rx_mode = RX_HOLD;
        for (int i = 0; i < 12; i++)
            send_number(rand_value(), ($urandom_range(0, 1) != 0) ? FUNC_HEX_UP : FUNC_OCT);
        wait_drained();

        // back-to-back stretch, no stalls on either side
        while (rx_mode == RX_HOLD) @(posedge aclk);
        rx_mode    = RX_FREE;
        tx_idle_en = 1'b0;
        send_random(25);
        rx_mode    = RX_RANDOM;
        tx_idle_en = 1'b1;

        send_random(30);
        wait_drained();
        repeat (80) @(posedge aclk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
